/* hw/rtl/owm_pkg.sv */
// owm_pkg: shared types and constants of the single-wire bus master
// used by owm_seq and onewire_bus_master; no dependencies

package owm_pkg;

    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 10;
    localparam int unsigned TickW     = 10;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_WRITE_SLOT    = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_READ_SAMPLE   = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_READ_RECOVERY = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_LOW_PULSE     = 3'd5;

    // command kinds
    localparam logic [1:0] ACT_RESET = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_WR_SLOT  = 3'd3,
        PH_RD_LOW   = 3'd4,
        PH_RD_WAIT  = 3'd5,
        PH_RD_REC   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [9:0] presence_wait_ticks;
        logic [7:0] write_slot_ticks;
        logic [7:0] read_sample_ticks;
        logic [7:0] read_recovery_ticks;
        logic [3:0] low_pulse_ticks;
    } owm_cfg_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       line_release;
    } owm_res_t;

endpackage

/* hw/rtl/owm_seq.sv */
// owm_seq: bus sequencer state (phase, tick counter, bit index, shift byte)
// and the per-tick step logic; depends on owm_pkg

module owm_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              start_req,
    input  logic [1:0]        action,
    input  logic [7:0]        write_data,
    input  logic              line_level,
    input  owm_pkg::owm_cfg_t cfg,
    output owm_pkg::owm_res_t res
);
    import owm_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [TickW-1:0] tick_reg, tick_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;
    logic             presence_reg, presence_next;
    logic [7:0]       rbyte_reg, rbyte_next;

    phase_t           ph;
    logic [TickW-1:0] tc;
    logic [2:0]       bi;
    logic [7:0]       sb;
    logic [TickW:0]   nxt;
    logic             go, bit_end, wbit;
    logic [TickW:0]   lp, rst_len, pres_len, slot_len, samp_len, rec_len;

    always_comb
    begin
        lp       = (cfg.low_pulse_ticks == 4'd0) ? 11'd1 : {7'd0, cfg.low_pulse_ticks};
        rst_len  = (cfg.reset_low_ticks == 10'd0) ? 11'd1 : {1'b0, cfg.reset_low_ticks};
        pres_len = (cfg.presence_wait_ticks == 10'd0) ? 11'd1
                                                      : {1'b0, cfg.presence_wait_ticks};
        slot_len = (cfg.write_slot_ticks == 8'd0) ? 11'd1 : {3'd0, cfg.write_slot_ticks};
        samp_len = (cfg.read_sample_ticks == 8'd0) ? 11'd1 : {3'd0, cfg.read_sample_ticks};
        rec_len  = {3'd0, cfg.read_recovery_ticks};
    end

    // command start folds into the first tick
    always_comb
    begin
        go = (phase_reg == PH_IDLE) && start_req && (action != ACT_NONE);
        ph = phase_reg;
        tc = tick_reg;
        bi = bit_reg;
        sb = shift_reg;
        if (go)
        begin
            tc = '0;
            bi = '0;
            case (action)
                ACT_RESET: ph = PH_RST_LOW;
                ACT_WRITE:
                begin
                    ph = PH_WR_SLOT;
                    sb = write_data;
                end
                default:
                begin
                    ph = PH_RD_LOW;
                    sb = '0;
                end
            endcase
        end
        nxt = {1'b0, tc} + 11'd1;
    end

    always_comb
    begin
        phase_next    = ph;
        tick_next     = tc;
        bit_next      = bi;
        shift_next    = sb;
        presence_next = presence_reg;
        rbyte_next    = rbyte_reg;
        bit_end       = 1'b0;
        wbit          = sb[bi];
        res.line_release = 1'b1;
        res.busy_res     = (ph != PH_IDLE);
        res.done_res     = 1'b0;

        case (ph)
            PH_RST_LOW:
            begin
                res.line_release = 1'b0;
                if (nxt >= rst_len)
                begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = '0;
                end
                else
                    tick_next = nxt[TickW-1:0];
            end
            PH_RST_WAIT:
            begin
                if (nxt >= pres_len)
                begin
                    presence_next = ~line_level;
                    res.done_res  = 1'b1;
                    phase_next    = PH_IDLE;
                    tick_next     = '0;
                    bit_next      = '0;
                end
                else
                    tick_next = nxt[TickW-1:0];
            end
            PH_WR_SLOT:
            begin
                res.line_release = wbit && ({1'b0, tc} >= lp);
                if (nxt >= slot_len)
                begin
                    tick_next = '0;
                    if (bi == 3'd7)
                    begin
                        res.done_res = 1'b1;
                        phase_next   = PH_IDLE;
                        bit_next     = '0;
                    end
                    else
                        bit_next = bi + 3'd1;
                end
                else
                    tick_next = nxt[TickW-1:0];
            end
            PH_RD_LOW:
            begin
                res.line_release = 1'b0;
                if (nxt >= lp)
                begin
                    phase_next = PH_RD_WAIT;
                    tick_next  = '0;
                end
                else
                    tick_next = nxt[TickW-1:0];
            end
            PH_RD_WAIT:
            begin
                if (nxt >= samp_len)
                begin
                    if (line_level)
                        shift_next[bi] = 1'b1;
                    if (cfg.read_recovery_ticks == 8'd0)
                        bit_end = 1'b1;
                    else
                    begin
                        phase_next = PH_RD_REC;
                        tick_next  = '0;
                    end
                end
                else
                    tick_next = nxt[TickW-1:0];
            end
            PH_RD_REC:
            begin
                if (nxt >= rec_len)
                    bit_end = 1'b1;
                else
                    tick_next = nxt[TickW-1:0];
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase

        if (bit_end)
        begin
            tick_next = '0;
            if (bi == 3'd7)
            begin
                rbyte_next   = shift_next;
                res.done_res = 1'b1;
                phase_next   = PH_IDLE;
                bit_next     = '0;
            end
            else
            begin
                bit_next   = bi + 3'd1;
                phase_next = PH_RD_LOW;
            end
        end

        res.presence  = presence_next;
        res.read_data = rbyte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            rbyte_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            rbyte_reg    <= rbyte_next;
        end
    end

endmodule

/* hw/rtl/onewire_bus_master.sv */
// onewire_bus_master: single-wire bus master, one item per bus tick
// depends on owm_pkg and owm_seq
//
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tick: command request, write byte, sampled line
//  m_*      | out       | tick result: line drive, busy, done, presence, byte
//  cfg_*    | in        | register write: index and data
//
// one item per clock while s_tready is high: the step logic sits between the
// sequencer state and one output register, so items are taken back to back
// m_tvalid rises in the cycle after the accept
// s_tready drops only while the output register holds an item m_tready refuses
// reset puts the sequencer idle and loads the register defaults

module onewire_bus_master (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // write_data[7:0], line_level[8]
    input  logic [2:0]                      s_tuser,   // start_req[0], action[2:1]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // line_release[0], busy_res[1],
                                                       // done_res[2], presence[3],
                                                       // read_data[11:4]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owm_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [owm_pkg::CfgDataW-1:0]    cfg_data
);
    import owm_pkg::*;

    owm_cfg_t cfg_reg;
    owm_res_t step_res;
    owm_res_t res_reg;
    logic     out_valid_reg;
    logic     accept;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= 10'd480;
            cfg_reg.presence_wait_ticks <= 10'd112;
            cfg_reg.write_slot_ticks    <= 8'd60;
            cfg_reg.read_sample_ticks   <= 8'd15;
            cfg_reg.read_recovery_ticks <= 8'd45;
            cfg_reg.low_pulse_ticks     <= 4'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RESET_LOW:     cfg_reg.reset_low_ticks     <= cfg_data;
                REG_PRESENCE_WAIT: cfg_reg.presence_wait_ticks <= cfg_data;
                REG_WRITE_SLOT:    cfg_reg.write_slot_ticks    <= cfg_data[7:0];
                REG_READ_SAMPLE:   cfg_reg.read_sample_ticks   <= cfg_data[7:0];
                REG_READ_RECOVERY: cfg_reg.read_recovery_ticks <= cfg_data[7:0];
                REG_LOW_PULSE:     cfg_reg.low_pulse_ticks     <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    owm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .start_req  (s_tuser[0]),
        .action     (s_tuser[2:1]),
        .write_data (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .cfg        (cfg_reg),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.read_data, res_reg.presence, res_reg.done_res,
                       res_reg.busy_res, res_reg.line_release};

endmodule

/* dv/onewire_bus_master_checker.sv */
// onewire_bus_master_checker: watches the tick, result and register channels of the
// single-wire bus master, predicts every tick result and compares it field by field
// depends on owm_pkg

module onewire_bus_master_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,
    input  logic [2:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [owm_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [owm_pkg::CfgDataW-1:0]  cfg_data,
    output int                            fail_count,
    output int                            outstanding,
    output int                            cmds_done,
    output logic                          seq_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    import owm_pkg::*;

    // predicted sequencer state and register copy
    owm_cfg_t   cfg;
    phase_t     phase;
    logic [9:0] tick_cnt;
    logic [2:0] bit_idx;
    logic [7:0] shift_q;
    logic       presence_q;
    logic [7:0] read_q;

    owm_res_t   tick_results[$];
    owm_res_t   want_res;
    owm_res_t   got_res;

    function automatic logic [10:0] len_or_one(input logic [9:0] v);
        return (v == 10'd0) ? 11'd1 : {1'b0, v};
    endfunction

    task automatic end_command(inout owm_res_t res);
        res.done_res = 1'b1;
        phase        = PH_IDLE;
        tick_cnt     = '0;
        bit_idx      = '0;
    endtask

    // one bus tick: advances the predicted sequencer and returns the tick result
    task automatic step_bus(input logic start, input logic [1:0] act,
                            input logic [7:0] wbyte, input logic line,
                            output owm_res_t res);
        logic [10:0] nxt;
        logic [10:0] pulse;
        logic        bit_end;
        nxt              = {1'b0, tick_cnt} + 11'd1;
        pulse            = len_or_one({6'd0, cfg.low_pulse_ticks});
        bit_end          = 1'b0;
        res              = '0;
        res.line_release = 1'b1;

        if (phase == PH_IDLE && start && act != ACT_NONE)
        begin
            tick_cnt = '0;
            nxt      = 11'd1;
            bit_idx  = '0;
            case (act)
                ACT_RESET:
                begin
                    phase = PH_RST_LOW;
                end
                ACT_WRITE:
                begin
                    shift_q = wbyte;
                    phase   = PH_WR_SLOT;
                end
                default:
                begin
                    shift_q = '0;
                    phase   = PH_RD_LOW;
                end
            endcase
        end

        res.busy_res = (phase != PH_IDLE);

        case (phase)
            PH_RST_LOW:
            begin
                res.line_release = 1'b0;
                if (nxt >= len_or_one(cfg.reset_low_ticks))
                begin
                    phase    = PH_RST_WAIT;
                    tick_cnt = '0;
                end
                else
                begin
                    tick_cnt = nxt[9:0];
                end
            end
            PH_RST_WAIT:
            begin
                if (nxt >= len_or_one(cfg.presence_wait_ticks))
                begin
                    // a device answers by pulling the line low
                    presence_q = ~line;
                    end_command(res);
                end
                else
                begin
                    tick_cnt = nxt[9:0];
                end
            end
            PH_WR_SLOT:
            begin
                // a one bit lets go of the line once the opening pulse is over
                res.line_release = shift_q[bit_idx] && ({1'b0, tick_cnt} >= pulse);
                if (nxt >= len_or_one({2'd0, cfg.write_slot_ticks}))
                begin
                    if (bit_idx == 3'd7)
                    begin
                        end_command(res);
                    end
                    else
                    begin
                        bit_idx  = bit_idx + 3'd1;
                        tick_cnt = '0;
                    end
                end
                else
                begin
                    tick_cnt = nxt[9:0];
                end
            end
            PH_RD_LOW:
            begin
                res.line_release = 1'b0;
                if (nxt >= pulse)
                begin
                    phase    = PH_RD_WAIT;
                    tick_cnt = '0;
                end
                else
                begin
                    tick_cnt = nxt[9:0];
                end
            end
            PH_RD_WAIT:
            begin
                if (nxt >= len_or_one({2'd0, cfg.read_sample_ticks}))
                begin
                    if (line)
                    begin
                        shift_q[bit_idx] = 1'b1;
                    end
                    if (cfg.read_recovery_ticks == 8'd0)
                    begin
                        bit_end = 1'b1;
                    end
                    else
                    begin
                        phase    = PH_RD_REC;
                        tick_cnt = '0;
                    end
                end
                else
                begin
                    tick_cnt = nxt[9:0];
                end
            end
            PH_RD_REC:
            begin
                if (nxt >= {3'd0, cfg.read_recovery_ticks})
                begin
                    bit_end = 1'b1;
                end
                else
                begin
                    tick_cnt = nxt[9:0];
                end
            end
            default:
            begin
                phase    = PH_IDLE;
                tick_cnt = '0;
            end
        endcase

        if (bit_end)
        begin
            if (bit_idx == 3'd7)
            begin
                read_q = shift_q;
                end_command(res);
            end
            else
            begin
                bit_idx  = bit_idx + 3'd1;
                phase    = PH_RD_LOW;
                tick_cnt = '0;
            end
        end

        res.presence  = presence_q;
        res.read_data = read_q;
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg         = '{10'd480, 10'd112, 8'd60, 8'd15, 8'd45, 4'd1};
            phase       = PH_IDLE;
            tick_cnt    = '0;
            bit_idx     = '0;
            shift_q     = '0;
            presence_q  = 1'b0;
            read_q      = '0;
            fail_count  = 0;
            tick_results.delete();
            outstanding <= 0;
            cmds_done   <= 0;
            seq_busy    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RESET_LOW:     cfg.reset_low_ticks     = cfg_data;
                    REG_PRESENCE_WAIT: cfg.presence_wait_ticks = cfg_data;
                    REG_WRITE_SLOT:    cfg.write_slot_ticks    = cfg_data[7:0];
                    REG_READ_SAMPLE:   cfg.read_sample_ticks   = cfg_data[7:0];
                    REG_READ_RECOVERY: cfg.read_recovery_ticks = cfg_data[7:0];
                    REG_LOW_PULSE:     cfg.low_pulse_ticks     = cfg_data[3:0];
                    default:           ;
                endcase
            end

            // a result taken now belongs to an earlier tick, so pop before push
            if (m_tvalid && m_tready)
            begin
                got_res = owm_res_t'(m_tdata[11:0]);
                if (tick_results.size() == 0)
                begin
                    $error("result item with no tick waiting: %0h", m_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want_res = tick_results.pop_front();
                    check_field("line_release", {7'd0, want_res.line_release},
                                {7'd0, got_res.line_release});
                    check_field("busy_res", {7'd0, want_res.busy_res},
                                {7'd0, got_res.busy_res});
                    check_field("done_res", {7'd0, want_res.done_res},
                                {7'd0, got_res.done_res});
                    check_field("presence", {7'd0, want_res.presence},
                                {7'd0, got_res.presence});
                    check_field("read_data", want_res.read_data, got_res.read_data);
                end
            end

            if (s_tvalid && s_tready)
            begin
                step_bus(s_tuser[0], s_tuser[2:1], s_tdata[7:0], s_tdata[8], want_res);
                tick_results.push_back(want_res);
                if (want_res.done_res)
                begin
                    cmds_done <= cmds_done + 1;
                end
            end

            outstanding <= tick_results.size();
            seq_busy    <= (phase != PH_IDLE);
        end
    end

endmodule

/* dv/onewire_bus_master_tb.sv */
// onewire_bus_master_tb: clock, reset, tick and register stimulus and the verdict
// depends on owm_pkg, onewire_bus_master and onewire_bus_master_checker

module onewire_bus_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owm_pkg::*;

    // indexes past the register list, writes there must change nothing
    localparam logic [CfgIndexW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CfgIndexW-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    int   fail_count;
    int   outstanding;
    int   cmds_done;
    logic seq_busy;

    int   send_idle_pct = 17;
    int   recv_idle_pct = 57;

    onewire_bus_master u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    onewire_bus_master_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .cmds_done   (cmds_done),
        .seq_busy    (seq_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid is left high after the accept so back to back items need no toggle
    task automatic send_tick(input logic start, input logic [1:0] act,
                             input logic [7:0] wbyte, input logic line);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, line, wbyte};
        s_tuser  <= {act, start};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_tick();
        logic [1:0] act;
        act = ($urandom_range(9) == 0) ? ACT_NONE : 2'($urandom_range(2));
        send_tick($urandom_range(3) == 0, act, 8'($urandom), 1'($urandom));
    endtask

    // lets the sequencer run out with plain ticks until no result is owed
    task automatic wait_bus_idle();
        int seen;
        s_tvalid <= 1'b0;
        forever
        begin
            @(posedge clk);
            while (outstanding != 0)
            begin
                @(posedge clk);
            end
            if (!seq_busy)
            begin
                break;
            end
            seen = cmds_done;
            while (cmds_done == seen)
            begin
                send_tick(1'b0, ACT_NONE, 8'($urandom), 1'($urandom));
            end
            s_tvalid <= 1'b0;
        end
    endtask

    // starts one command, keeps ticking with ignored requests until it ends
    task automatic run_command(input logic [1:0] act);
        int seen;
        seen = cmds_done;
        send_tick(1'b1, act, 8'($urandom), 1'($urandom));
        while (cmds_done == seen)
        begin
            random_tick();
        end
        wait_bus_idle();
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // unused high data bits of the narrow registers carry junk
    task automatic load_config(input owm_cfg_t c);
        write_reg(CfgIndexW'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 10'($urandom));
        write_reg(REG_RESET_LOW, c.reset_low_ticks);
        write_reg(REG_PRESENCE_WAIT, c.presence_wait_ticks);
        write_reg(REG_WRITE_SLOT, {2'($urandom), c.write_slot_ticks});
        write_reg(REG_READ_SAMPLE, {2'($urandom), c.read_sample_ticks});
        write_reg(REG_READ_RECOVERY, {2'($urandom), c.read_recovery_ticks});
        write_reg(REG_LOW_PULSE, {6'($urandom), c.low_pulse_ticks});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        owm_cfg_t   setting;
        logic [7:0] rd_pattern;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults straight out of reset
        run_command(ACT_READ);

        // all lengths zero: each acts as one, recovery is skipped,
        // and the write pulse covers the whole slot
        load_config('0);
        send_tick(1'b1, ACT_NONE, 8'hFF, 1'b1);
        send_tick(1'b0, ACT_WRITE, 8'h00, 1'b0);
        send_tick(1'b1, ACT_RESET, 8'h00, 1'b0);
        send_tick(1'b1, ACT_READ, 8'hFF, 1'b0);
        send_tick(1'b1, ACT_RESET, 8'hFF, 1'b1);
        send_tick(1'b1, ACT_WRITE, 8'h00, 1'b1);
        send_tick(1'b1, ACT_WRITE, 8'hA5, 1'b0);
        repeat (7) send_tick(1'b1, ACT_READ, 8'($urandom), 1'($urandom));
        rd_pattern = 8'h5A;
        for (int k = 0; k < 8; k++)
        begin
            send_tick(1'b1, (k == 0) ? ACT_READ : ACT_RESET, 8'($urandom), 1'($urandom));
            send_tick(1'b1, ACT_WRITE, 8'hFF, rd_pattern[k]);
        end
        wait_bus_idle();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 57 : 0;
            recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 17 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                if (mode == 0 && seg == 0)
                begin
                    setting = '{10'd1, 10'd1, 8'd1, 8'd1, 8'd0, 4'd1};
                end
                else
                begin
                    // low pulse often reaches the slot length on purpose
                    setting.reset_low_ticks     = 10'($urandom_range(1, 12));
                    setting.presence_wait_ticks = 10'($urandom_range(1, 12));
                    setting.write_slot_ticks    = 8'($urandom_range(1, 16));
                    setting.read_sample_ticks   = 8'($urandom_range(1, 8));
                    setting.read_recovery_ticks = 8'($urandom_range(0, 6));
                    setting.low_pulse_ticks     = 4'($urandom_range(1, 15));
                end
                load_config(setting);
                for (int i = 0; i < 80; i++)
                begin
                    random_tick();
                    if (seg == 1 && i == 64)
                    begin
                        // hold off until every owed result is out
                        s_tvalid <= 1'b0;
                        @(posedge clk);
                        while (outstanding != 0)
                        begin
                            @(posedge clk);
                        end
                    end
                end
                wait_bus_idle();
            end
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* onewire_bus_master.f */
hw/rtl/owm_pkg.sv
hw/rtl/owm_seq.sv
hw/rtl/onewire_bus_master.sv
dv/onewire_bus_master_checker.sv
dv/onewire_bus_master_tb.sv
